/* hdl/b64se_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Shared item types, the encoding alphabet and queue status for the encoder.
// ----------------------------------------------------------------------------
package b64se_pkg;

    localparam int GroupChars = 4;
    localparam int QueueDepth = 2;

    localparam logic [7:0] CharUpperA = 8'h41;
    localparam logic [7:0] CharLowerA = 8'h61;
    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharPlus   = 8'h2b;
    localparam logic [7:0] CharSlash  = 8'h2f;
    localparam logic [7:0] CharPad    = 8'h3d;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    typedef struct packed {
        logic [GroupChars-1:0][7:0] chars;
        logic                       last;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Maps one 6-bit value to its character of the standard alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = CharUpperA + {2'b00, v};
            [6'd26:6'd51]: c = CharLowerA + ({2'b00, v} - 8'd26);
            [6'd52:6'd61]: c = CharZero + ({2'b00, v} - 8'd52);
            6'd62:         c = CharPlus;
            default:       c = CharSlash;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* hdl/b64se_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Collects bytes into groups of three and encodes each finished or final
// group into four characters for the queue.
// ----------------------------------------------------------------------------
module b64se_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire b64se_pkg::in_item_t  s_data,
    input  wire b64se_pkg::q_status_t q_status,
    output logic                      push,
    output b64se_pkg::group_t         push_group
);
    import b64se_pkg::*;

    logic [1:0][7:0] pend_reg;
    logic [1:0][7:0] pend_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            accept;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [5:0]      s0;
    logic [5:0]      s1;
    logic [5:0]      s2;
    logic [5:0]      s3;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pend_next  = pend_reg;
        count_next = count_reg;
        push       = 1'b0;
        b0 = (count_reg != 2'd0) ? pend_reg[0] : s_data.data_byte;
        b1 = (count_reg == 2'd2) ? pend_reg[1] :
             ((count_reg == 2'd1) ? s_data.data_byte : 8'h00);
        b2 = (count_reg == 2'd2) ? s_data.data_byte : 8'h00;
        s0 = b0[7:2];
        s1 = {b0[1:0], b1[7:4]};
        s2 = {b1[3:0], b2[7:6]};
        s3 = b2[5:0];
        push_group.chars[0] = b64_char(s0);
        push_group.chars[1] = b64_char(s1);
        push_group.chars[2] = (count_reg == 2'd0) ? CharPad : b64_char(s2);
        push_group.chars[3] = (count_reg == 2'd2) ? b64_char(s3) : CharPad;
        push_group.last     = s_data.final_byte;
        if (accept) begin
            if (count_reg != 2'd2 && !s_data.final_byte) begin
                pend_next[count_reg[0]] = s_data.data_byte;
                count_next              = count_reg + 2'd1;
            end else begin
                push       = 1'b1;
                count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/b64se_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Two-entry queue of encoded groups between the front end and the back end.
// ----------------------------------------------------------------------------
module b64se_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire b64se_pkg::group_t    push_group,
    input  wire logic                 pop,
    output b64se_pkg::group_t         head_group,
    output b64se_pkg::q_status_t      q_status
);
    import b64se_pkg::*;

    group_t     mem_reg [QueueDepth];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head_group     = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == 2'(QueueDepth));
    assign q_status.empty = (count_reg == 2'd0);

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/b64se_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Sends the four characters of the head group one per cycle, while m_ready is
// high, through an output register.
// ----------------------------------------------------------------------------
module b64se_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire b64se_pkg::group_t    head_group,
    input  wire b64se_pkg::q_status_t q_status,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output b64se_pkg::out_item_t      m_data
);
    import b64se_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    out_item_t  out_reg;
    out_item_t  out_next;
    logic       load;

    assign m_valid = valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        load       = !q_status.empty && (!valid_reg || m_ready);
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_ready;
        out_next   = out_reg;
        pop        = 1'b0;
        if (load) begin
            out_next.out_char  = head_group.chars[idx_reg];
            out_next.last_char = head_group.last && (idx_reg == 2'd3);
            valid_next         = 1'b1;
            idx_next           = idx_reg + 2'd1;
            pop                = (idx_reg == 2'd3);
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/base64_stream_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into standard base64 characters with '=' padding.
// ----------------------------------------------------------------------------
// The s_ channel takes one byte per item; final_byte marks the last byte of a
// message. The m_ channel gives one ASCII character per item; last_char marks
// the final character of the message.
// Every third byte, and every final byte, closes a group of four characters.
// A short final group is zero-filled and padded with '='.
// The first character of a group passes from the queue through the output
// register onto m_, and the rest follow one per cycle while m_ready is high.
// The output runs at one character per cycle while m_ready is high, set by
// the back end that sends the four characters of a group through a single
// output register. Full groups give four characters per three bytes, so input
// bytes are taken every cycle as long as the two-group queue has room.
// When the receiver stalls, the queue fills and s_ready drops; no data is lost.
// Reset clears the pending byte count, the queue and the output valid.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire b64se_pkg::in_item_t   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output b64se_pkg::out_item_t       m_data
);
    import b64se_pkg::*;

    q_status_t q_status;
    group_t    push_group;
    group_t    head_group;
    logic      push;
    logic      pop;

    b64se_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    b64se_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head_group (head_group),
        .q_status   (q_status)
    );

    b64se_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_group (head_group),
        .q_status   (q_status),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !push)
        else $error("group pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.empty |-> !pop)
        else $error("group popped from an empty queue");

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_last_only_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last_char && !$past(m_valid && !m_ready)) |->
            $past(pop))
        else $error("last character sent without finishing its group");
`endif

endmodule
`default_nettype wire
